FILE: design/cda_pkg.sv
// Shared types, constants, micro-op codes and calendar helpers for the date adder.
package cda_pkg;

	// Width of the count field; the block supports 8 to 32.
	localparam int COUNT_WIDTH = 16;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;

	localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd16383;
	localparam logic [YEAR_W-1:0] YEAR_400 = 14'd400;
	localparam logic [YEAR_W-1:0] MOD400_TOP = 14'd399;

	// Days in one full 400-year Gregorian cycle.
	localparam int SPAN_DAYS = 146097;
	localparam int SPAN_W    = 18;
	localparam int CE_W      = (COUNT_WIDTH > SPAN_W) ? COUNT_WIDTH : SPAN_W;

	// Month-add working widths: total months, total / 4, year sum.
	localparam int TOT_W  = COUNT_WIDTH + 1;
	localparam int QX_W   = TOT_W - 2;
	localparam int YSUM_W = ((TOT_W > YEAR_W) ? TOT_W : YEAR_W) + 1;

	// Divide by 3 through a reciprocal: exact for any operand below 2**32.
	localparam int          PROD_W     = QX_W + 32;
	localparam logic [31:0] DIV3_MAGIC = 32'hAAAAAAAB;
	localparam int          DIV3_SHIFT = 33;

	// Microcode store geometry and entry points.
	localparam int UPC_W   = 5;
	localparam int SHIFT_W = 3;

	localparam logic [UPC_W-1:0] UA_IDLE  = 5'd0;
	localparam logic [UPC_W-1:0] UA_RED0  = 5'd1;
	localparam logic [UPC_W-1:0] UA_MINIT = 5'd8;
	localparam logic [UPC_W-1:0] UA_MDIV  = 5'd9;
	localparam logic [UPC_W-1:0] UA_D400  = 5'd18;
	localparam logic [UPC_W-1:0] UA_WALK  = 5'd19;
	localparam logic [UPC_W-1:0] UA_OUT   = 5'd20;

	typedef struct packed {
		logic                   action;
		logic [DAY_W-1:0]       day;
		logic [MONTH_W-1:0]     month;
		logic [YEAR_W-1:0]      year;
		logic [COUNT_WIDTH-1:0] count;
	} cda_in_t;

	typedef struct packed {
		logic [DAY_W-1:0]   result_day;
		logic [MONTH_W-1:0] result_month;
		logic [YEAR_W-1:0]  result_year;
	} cda_out_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_RED,
		OP_CLAMP,
		OP_D400,
		OP_WALK,
		OP_MINIT,
		OP_MDIV,
		OP_MADD,
		OP_OUT
	} cda_op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_IN_VALID,
		C_DAYS,
		C_GE_SPAN,
		C_NOT_FIT,
		C_OUT_FREE
	} cda_cond_t;

	// One control word: operation, jump condition and target, hold-when-false,
	// and the shift amount used by the mod-400 reduction steps.
	typedef struct packed {
		cda_op_t            op;
		cda_cond_t          cond;
		logic [UPC_W-1:0]   target;
		logic               hold;
		logic [SHIFT_W-1:0] shift;
	} cda_uword_t;

	// Status from the datapath that the sequencer branches on.
	typedef struct packed {
		logic days;
		logic ge_span;
		logic not_fit;
		logic out_free;
	} cda_flags_t;

	function automatic logic is_leap(input logic [8:0] ymod);
		logic mul4;
		mul4 = (ymod[1:0] == 2'd0);
		return (mul4 && ymod != 9'd100 && ymod != 9'd200 && ymod != 9'd300)
			|| (ymod == 9'd0);
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

FILE: design/cda_ucode_rom.sv
// Microcode store: the date-add program, one control word per step.
module cda_ucode_rom
	import cda_pkg::*;
(
	input  logic [UPC_W-1:0] addr,
	output cda_uword_t       word
);

	always_comb begin
		unique case (addr)
			// wait for an item, load it
			5'd0:  word = '{OP_LOAD,  C_IN_VALID,  UA_RED0,  1'b1, 3'd0};
			// year mod 400 by restoring subtraction of 400 << k
			5'd1:  word = '{OP_RED,   C_NEVER,     UA_IDLE,  1'b0, 3'd5};
			5'd2:  word = '{OP_RED,   C_NEVER,     UA_IDLE,  1'b0, 3'd4};
			5'd3:  word = '{OP_RED,   C_NEVER,     UA_IDLE,  1'b0, 3'd3};
			5'd4:  word = '{OP_RED,   C_NEVER,     UA_IDLE,  1'b0, 3'd2};
			5'd5:  word = '{OP_RED,   C_NEVER,     UA_IDLE,  1'b0, 3'd1};
			5'd6:  word = '{OP_RED,   C_NEVER,     UA_IDLE,  1'b0, 3'd0};
			// clamp day, branch on action
			5'd7:  word = '{OP_CLAMP, C_DAYS,      UA_D400,  1'b0, 3'd0};
			// month add: total months, divide by 12 by reciprocal, add to year, reduce mod 400, clamp
			5'd8:  word = '{OP_MINIT, C_NEVER,     UA_IDLE,  1'b0, 3'd0};
			5'd9:  word = '{OP_MDIV,  C_NEVER,     UA_IDLE,  1'b0, 3'd0};
			5'd10: word = '{OP_MADD,  C_NEVER,     UA_IDLE,  1'b0, 3'd0};
			5'd11: word = '{OP_RED,   C_NEVER,     UA_IDLE,  1'b0, 3'd5};
			5'd12: word = '{OP_RED,   C_NEVER,     UA_IDLE,  1'b0, 3'd4};
			5'd13: word = '{OP_RED,   C_NEVER,     UA_IDLE,  1'b0, 3'd3};
			5'd14: word = '{OP_RED,   C_NEVER,     UA_IDLE,  1'b0, 3'd2};
			5'd15: word = '{OP_RED,   C_NEVER,     UA_IDLE,  1'b0, 3'd1};
			5'd16: word = '{OP_RED,   C_NEVER,     UA_IDLE,  1'b0, 3'd0};
			5'd17: word = '{OP_CLAMP, C_ALWAYS,    UA_OUT,   1'b0, 3'd0};
			// day add: whole 400-year spans, then the month walk
			5'd18: word = '{OP_D400,  C_GE_SPAN,   UA_D400,  1'b0, 3'd0};
			5'd19: word = '{OP_WALK,  C_NOT_FIT,   UA_WALK,  1'b0, 3'd0};
			// hand the result to the output register
			5'd20: word = '{OP_OUT,   C_OUT_FREE,  UA_IDLE,  1'b1, 3'd0};
			default: word = '{OP_NOP, C_ALWAYS,    UA_IDLE,  1'b0, 3'd0};
		endcase
	end

endmodule

FILE: design/cda_sequencer.sv
// Microcode sequencer: step counter, condition select and next-address logic.
module cda_sequencer
	import cda_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  cda_flags_t flags,
	output cda_uword_t word,
	output logic       idle
);

	logic [UPC_W-1:0] upc_q;
	logic [UPC_W-1:0] upc_d;
	logic             take;

	cda_ucode_rom u_rom (
		.addr (upc_q),
		.word (word)
	);

	always_comb begin
		unique case (word.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_IN_VALID:  take = in_valid;
			C_DAYS:      take = flags.days;
			C_GE_SPAN:   take = flags.ge_span;
			C_NOT_FIT:   take = flags.not_fit;
			C_OUT_FREE:  take = flags.out_free;
			default:     take = 1'b0;
		endcase
	end

	always_comb begin
		if (take) begin
			upc_d = word.target;
		end else if (word.hold) begin
			upc_d = upc_q;
		end else begin
			upc_d = upc_q + 5'd1;
		end
	end

	always_comb begin
		idle = (upc_q == UA_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

FILE: design/cda_datapath.sv
// Date datapath: day, month, year and count registers driven by the control word.
module cda_datapath
	import cda_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cda_uword_t word,
	input  logic       load,
	input  cda_in_t    in_data,
	input  logic       out_ready,
	output cda_flags_t flags,
	output logic       out_valid,
	output cda_out_t   out_data
);

	logic [DAY_W-1:0]       d_q;
	logic [MONTH_W-1:0]     m_q;
	logic [YEAR_W-1:0]      y_q;
	logic [YEAR_W-1:0]      s_q;
	logic                   ovf_q;
	logic                   act_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [TOT_W-1:0]       tot_q;
	logic [QX_W-1:0]        quo_q;
	logic                   out_valid_q;
	cda_out_t               out_q;

	logic                   leap;
	logic [DAY_W-1:0]       mdays;
	logic [DAY_W-1:0]       rest;
	logic                   fit;
	logic                   ge_span;
	logic                   out_free;
	logic [YEAR_W-1:0]      red_sub;
	logic [YEAR_W:0]        y_inc;
	logic [YEAR_W:0]        y_add400;
	logic [YSUM_W-1:0]      y_madd;
	logic [PROD_W-1:0]      prod;
	logic [QX_W-1:0]        quo;
	logic [MONTH_W-1:0]     m12_lo;
	logic [MONTH_W-1:0]     mrem;

	always_comb begin
		leap     = is_leap(s_q[8:0]);
		mdays    = month_days(m_q, leap);
		rest     = mdays - d_q;
		fit      = (cnt_q <= COUNT_WIDTH'(rest));
		ge_span  = (CE_W'(cnt_q) >= CE_W'(SPAN_DAYS));
		out_free = !out_valid_q || out_ready;
		red_sub  = YEAR_400 << word.shift;
		y_inc    = {1'b0, y_q} + 15'd1;
		y_add400 = {1'b0, y_q} + {1'b0, YEAR_400};
		// total / 12 as (total / 4) / 3
		prod     = PROD_W'(tot_q[TOT_W-1:2]) * PROD_W'(DIV3_MAGIC);
		quo      = QX_W'(prod >> DIV3_SHIFT);
		y_madd   = YSUM_W'(y_q) + YSUM_W'(quo_q);
		// remainder only needs the low four bits of total - 12 * quotient
		m12_lo   = {quo_q[0], 3'b000} + {quo_q[1:0], 2'b00};
		mrem     = tot_q[3:0] - m12_lo;
	end

	always_comb begin
		flags.days      = !act_q;
		flags.ge_span   = ge_span;
		flags.not_fit   = !fit;
		flags.out_free  = out_free;
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (word.op)
			OP_LOAD: begin
				if (load) begin
					d_q   <= (in_data.day == 5'd0) ? 5'd1 : in_data.day;
					m_q   <= (in_data.month == 4'd0) ? 4'd1 :
						((in_data.month > 4'd12) ? 4'd12 : in_data.month);
					y_q   <= in_data.year;
					s_q   <= in_data.year;
					ovf_q <= 1'b0;
					act_q <= in_data.action;
					cnt_q <= in_data.count;
				end
			end
			OP_RED: begin
				if (s_q >= red_sub) begin
					s_q <= s_q - red_sub;
				end
			end
			OP_CLAMP: begin
				if (d_q > mdays) begin
					d_q <= mdays;
				end
			end
			OP_D400: begin
				if (ge_span) begin
					cnt_q <= COUNT_WIDTH'(CE_W'(cnt_q) - CE_W'(SPAN_DAYS));
					y_q   <= y_add400[YEAR_W-1:0];
					ovf_q <= ovf_q | y_add400[YEAR_W];
				end
			end
			OP_WALK: begin
				if (fit) begin
					d_q <= d_q + cnt_q[DAY_W-1:0];
				end else begin
					cnt_q <= cnt_q - COUNT_WIDTH'({1'b0, rest} + 6'd1);
					d_q   <= 5'd1;
					if (m_q == 4'd12) begin
						m_q   <= 4'd1;
						y_q   <= y_inc[YEAR_W-1:0];
						ovf_q <= ovf_q | y_inc[YEAR_W];
						s_q   <= (s_q == MOD400_TOP) ? '0 : s_q + 14'd1;
					end else begin
						m_q <= m_q + 4'd1;
					end
				end
			end
			OP_MINIT: begin
				tot_q <= TOT_W'(m_q - 4'd1) + TOT_W'(cnt_q);
			end
			OP_MDIV: begin
				quo_q <= quo;
			end
			OP_MADD: begin
				m_q   <= mrem + 4'd1;
				y_q   <= y_madd[YEAR_W-1:0];
				s_q   <= y_madd[YEAR_W-1:0];
				ovf_q <= ovf_q | (y_madd > YSUM_W'(YEAR_MAX));
			end
			default: begin
			end
		endcase
	end

	// output register: payload
	always_ff @(posedge clk) begin
		if (word.op == OP_OUT && out_free) begin
			out_q.result_day   <= ovf_q ? 5'd31 : d_q;
			out_q.result_month <= ovf_q ? 4'd12 : m_q;
			out_q.result_year  <= ovf_q ? YEAR_MAX : y_q;
		end
	end

	// output register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (word.op == OP_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: design/calendar_date_add.sv
// Top level of the Gregorian date adder: sequencer plus datapath.
//
// Adds a count of days (action 0) or months (action 1) to a Gregorian date and
// returns one date per item; a result year above 16383 saturates to 31/12/16383.
// A short microprogram in a read-only table steps a plain datapath. Every item
// is loaded, has its year reduced mod 400 (leap rule) and its day clamped, and
// hands its result to the output register. Day addition first removes whole
// 146097-day spans (none fit a 16-bit count), then walks the date month by
// month until the rest of the count fits within the current month. Month
// addition forms the total months, divides by 12 through a reciprocal
// multiply, adds the quotient into the year, then runs another mod-400
// reduction and clamp of the new date.
// One item is in work at a time; the next item is taken as soon as the program
// returns to its idle step, even while the previous result still waits in the
// output register for its transfer.
module calendar_date_add
	import cda_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  cda_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output cda_out_t out_data
);

	cda_uword_t word;
	cda_flags_t flags;
	logic       idle;

	// Sequencer: hold at the idle step until an item arrives, then run the program.
	cda_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.flags    (flags),
		.word     (word),
		.idle     (idle)
	);

	// Accept only at the idle step; the load happens on that same edge.
	assign in_ready = idle;

	// Datapath: executes the control word and owns the output register.
	cda_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.word      (word),
		.load      (in_valid && idle),
		.in_data   (in_data),
		.out_ready (out_ready),
		.flags     (flags),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

FILE: test/tb.sv
// Self-checking testbench for calendar_date_add: queued stimulus, own date predictor.
`timescale 1ns / 100ps

module tb;
	import cda_pkg::*;

	typedef enum logic {
		ACT_DAYS,
		ACT_MONTHS
	} date_action_t;

	// One queued stimulus item: payload, idle cycles before it, and whether the
	// sender must wait for every outstanding result before offering it.
	typedef struct {
		cda_in_t     stim;
		int unsigned gap;
		bit          drain;
	} date_job_t;

	// One outstanding expectation: the item that caused it and the date it must give.
	typedef struct {
		cda_in_t  stim;
		cda_out_t want;
	} date_check_t;

	localparam int WATCHDOG_LIMIT = 12000;
	localparam int DRAIN_CYCLES   = 2200;
	localparam int RANDOM_ITEMS   = 246;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	cda_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	cda_out_t out_data;

	date_job_t   jobs[$];
	date_check_t expected_dates[$];

	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned n_accepted = 0;
	int unsigned n_checked = 0;
	int unsigned n_errors = 0;
	int unsigned quiet_cycles = 0;

	calendar_date_add dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #6 clk = ~clk;

	// Gregorian leap rule on the full year value, which may pass 16383 mid-walk.
	function automatic bit leap_year(input longint unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned days_in_month(input int unsigned m,
		input longint unsigned y);
		case (m)
			2:           return leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	// Compute the date that one item must produce.
	function automatic cda_out_t predict_date(input cda_in_t item);
		int unsigned       d;
		int unsigned       m;
		int unsigned       len;
		int unsigned       rest;
		longint unsigned   y;
		longint unsigned   n;
		longint unsigned   total;
		cda_out_t          res;
		d = item.day;
		m = item.month;
		y = item.year;
		n = item.count;
		// Fold out-of-range month and day into the nearest legal value.
		if (m == 0)
			m = 1;
		if (m > 12)
			m = 12;
		len = days_in_month(m, y);
		if (d == 0)
			d = 1;
		if (d > len)
			d = len;
		if (item.action == ACT_DAYS) begin
			// Skip whole 400-year cycles, then walk the rest month by month.
			y += 400 * (n / SPAN_DAYS);
			n = n % SPAN_DAYS;
			while (n > 0) begin
				rest = days_in_month(m, y) - d;
				if (n <= rest) begin
					d += int'(n);
					n = 0;
				end else begin
					n -= rest + 1;
					d = 1;
					m++;
					if (m > 12) begin
						m = 1;
						y++;
					end
				end
			end
		end else begin
			total = (m - 1) + n;
			y += total / 12;
			m = int'(total % 12) + 1;
			len = days_in_month(m, y);
			if (d > len)
				d = len;
		end
		// Saturate on year overflow.
		if (y > YEAR_MAX) begin
			d = 31;
			m = 12;
			y = YEAR_MAX;
		end
		res.result_day = DAY_W'(d);
		res.result_month = MONTH_W'(m);
		res.result_year = YEAR_W'(y);
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] ERROR: %s", $time, msg);
		n_errors++;
	endtask

	task automatic add_job(input date_action_t act, input int unsigned d,
		input int unsigned m, input int unsigned y, input int unsigned c,
		input int unsigned gap, input bit drain);
		date_job_t job;
		job.stim.action = act;
		job.stim.day = DAY_W'(d);
		job.stim.month = MONTH_W'(m);
		job.stim.year = YEAR_W'(y);
		job.stim.count = COUNT_WIDTH'(c);
		job.gap = gap;
		job.drain = drain;
		jobs.push_back(job);
	endtask

	// Driver: offer queued items, hold each until its transfer, predict on transfer.
	always @(posedge clk or negedge arst_n) begin
		int unsigned wait_left;
		bit          take;
		date_check_t chk;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			gap_left <= 0;
			n_accepted <= 0;
		end else begin
			take = in_valid && in_ready;
			wait_left = gap_left;
			if (take) begin
				chk.stim = in_data;
				chk.want = predict_date(in_data);
				expected_dates.push_back(chk);
				n_accepted <= n_accepted + 1;
				// Load the idle gap that precedes the next item.
				if (jobs.size() != 0)
					wait_left = jobs[0].gap;
			end
			if (in_valid && !take) begin
				// Hold valid and payload until the transfer.
			end else if (wait_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= wait_left - 1;
			end else if (jobs.size() != 0
				&& !(jobs[0].drain && (take || n_accepted != n_checked))) begin
				in_valid <= 1'b1;
				in_data <= jobs[0].stim;
				gap_left <= 0;
				jobs.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each result transfer with the oldest expectation, then
	// drop ready for a random number of cycles, except in quiet stretches.
	always @(posedge clk or negedge arst_n) begin
		int unsigned wait_left;
		date_check_t chk;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			n_checked <= 0;
		end else begin
			wait_left = stall_left;
			if (out_valid && out_ready) begin
				if (expected_dates.size() == 0) begin
					report_mismatch($sformatf("result %0d/%0d/%0d with no pending item",
						out_data.result_day, out_data.result_month,
						out_data.result_year));
				end else begin
					chk = expected_dates.pop_front();
					if (out_data.result_day !== chk.want.result_day)
						report_mismatch($sformatf(
							"item %0d: day got %0d want %0d (in act %0d %0d/%0d/%0d +%0d)",
							n_checked, out_data.result_day, chk.want.result_day,
							chk.stim.action, chk.stim.day, chk.stim.month,
							chk.stim.year, chk.stim.count));
					if (out_data.result_month !== chk.want.result_month)
						report_mismatch($sformatf(
							"item %0d: month got %0d want %0d (in act %0d %0d/%0d/%0d +%0d)",
							n_checked, out_data.result_month, chk.want.result_month,
							chk.stim.action, chk.stim.day, chk.stim.month,
							chk.stim.year, chk.stim.count));
					if (out_data.result_year !== chk.want.result_year)
						report_mismatch($sformatf(
							"item %0d: year got %0d want %0d (in act %0d %0d/%0d/%0d +%0d)",
							n_checked, out_data.result_year, chk.want.result_year,
							chk.stim.action, chk.stim.day, chk.stim.month,
							chk.stim.year, chk.stim.count));
				end
				n_checked <= n_checked + 1;
				wait_left = ((n_checked / 40) % 4 == 3) ? 0 : $urandom_range(0, 3);
			end
			if (wait_left != 0) begin
				out_ready <= 1'b0;
				stall_left <= wait_left - 1;
			end else begin
				out_ready <= 1'b1;
				stall_left <= 0;
			end
		end
	end

	// Watchdog: end the run when neither channel transfers for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] ERROR: no transfer for %0d cycles", $time, quiet_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		cda_in_t     it;
		int unsigned sel;
		int unsigned gap;

		// Directed items: field extremes, folding of bad dates, leap rule corners,
		// month-end clamping, year rollover and saturation.
		add_job(ACT_DAYS,   0,  0,     0,     0, 0, 0);
		add_job(ACT_DAYS,  31, 15,  2023,     0, 0, 0);
		add_job(ACT_DAYS,  31,  2,  1900,     0, 1, 0);
		add_job(ACT_DAYS,  31,  2,  2000,     0, 0, 0);
		add_job(ACT_DAYS,  30,  2,     0,     0, 0, 0);
		add_job(ACT_DAYS,  31, 12,  1999,     1, 2, 0);
		add_job(ACT_DAYS,  28,  2,  2000,     1, 0, 0);
		add_job(ACT_DAYS,  28,  2,  1900,     1, 0, 0);
		add_job(ACT_DAYS,  28,  2,  2100,   366, 3, 0);
		add_job(ACT_DAYS,   1,  1,     0, 65535, 0, 0);
		add_job(ACT_DAYS,  31, 12, 16383,     1, 0, 0);
		add_job(ACT_DAYS,  31, 12, 16383,     0, 0, 0);
		add_job(ACT_DAYS,  31, 15, 16383, 65535, 0, 0);
		add_job(ACT_DAYS,   1,  1, 16300, 32768, 1, 0);
		add_job(ACT_MONTHS, 31, 1, 2024,     1, 0, 0);
		add_job(ACT_MONTHS, 31, 1, 2023,     1, 0, 0);
		add_job(ACT_MONTHS, 31, 3, 2023,     1, 0, 0);
		add_job(ACT_MONTHS, 31, 13, 1600,    0, 2, 0);
		add_job(ACT_MONTHS,  0, 14, 16383,   0, 0, 0);
		add_job(ACT_MONTHS, 15, 12, 1999,    1, 0, 0);
		add_job(ACT_MONTHS, 29,  1, 2000,   11, 0, 0);
		add_job(ACT_MONTHS,  1,  1,     0, 65535, 0, 0);
		add_job(ACT_MONTHS, 31, 15, 16383, 65535, 0, 0);
		add_job(ACT_MONTHS, 31,  0, 10921, 65535, 3, 0);

		// Random items: mostly well-formed dates with random counts, some
		// malformed fields, extreme years and full-range counts.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			it.action = ($urandom_range(0, 1) == 0) ? ACT_DAYS : ACT_MONTHS;
			it.month = MONTH_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
				: $urandom_range(1, 12));
			it.day = DAY_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
				: $urandom_range(1, 28));
			sel = $urandom_range(0, 9);
			case (sel)
				0:       it.year = YEAR_W'($urandom_range(0, 16383));
				1:       it.year = YEAR_W'($urandom_range(16200, 16383));
				2:       it.year = YEAR_W'(100 * $urandom_range(0, 99));
				default: it.year = YEAR_W'($urandom_range(0, 9999));
			endcase
			sel = $urandom_range(0, 99);
			if (it.action == ACT_DAYS)
				it.count = COUNT_WIDTH'((sel < 60) ? $urandom_range(0, 400)
					: (sel < 85) ? $urandom_range(0, 4000) : $urandom_range(0, 65535));
			else
				it.count = COUNT_WIDTH'((sel < 50) ? $urandom_range(0, 24)
					: (sel < 80) ? $urandom_range(0, 2000) : $urandom_range(0, 65535));
			// Keep one stretch free of sender gaps.
			gap = (i >= 100 && i < 140) ? 0 : $urandom_range(0, 3);
			add_job(date_action_t'(it.action), it.day, it.month, it.year, it.count,
				gap, (i == 0 || i == 150));
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Advance until every item has been sent and every result checked.
		while (jobs.size() != 0 || in_valid || n_accepted != n_checked)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_dates.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				expected_dates.size()));

		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: filelist.f
design/cda_pkg.sv
design/cda_ucode_rom.sv
design/cda_sequencer.sv
design/cda_datapath.sv
design/calendar_date_add.sv
test/tb.sv
